### design/pssc_pkg.sv
// ----------------------------------------------------------------------------
// pssc_pkg
// Shared types and constants for the pump schedule safety controller.
// ----------------------------------------------------------------------------
package pssc_pkg;

    localparam int unsigned MS_PER_SECOND = 1000;
    localparam int          SEC_W         = 17;
    localparam int          DIV_W         = 18;
    localparam int          REG_ADDR_W    = 3;
    localparam int          CFG_DATA_W    = 17;
    localparam logic [30:0] DELAY_CLAMP   = 31'h7FFF_FFFF;

    localparam logic [REG_ADDR_W-1:0] REG_WINDOW_START = 3'd0;
    localparam logic [REG_ADDR_W-1:0] REG_WINDOW_STOP  = 3'd1;
    localparam logic [REG_ADDR_W-1:0] REG_ON_TIME      = 3'd2;
    localparam logic [REG_ADDR_W-1:0] REG_OFF_TIME     = 3'd3;
    localparam logic [REG_ADDR_W-1:0] REG_RISE_LIMIT   = 3'd4;
    localparam logic [REG_ADDR_W-1:0] REG_POLL_PERIOD  = 3'd5;

    localparam logic [1:0] ST_IDLE     = 2'd0;
    localparam logic [1:0] ST_STARTED  = 2'd1;
    localparam logic [1:0] ST_DRAINING = 2'd2;

    localparam logic [1:0] SW_NEUTRAL = 2'd0;
    localparam logic [1:0] SW_ACTIVE  = 2'd1;

    typedef struct packed {
        logic [31:0]       now_ms;
        logic [16:0]       day_second;
        logic signed [15:0] level_reading;
        logic [1:0]        switch_reading;
        logic              manual_on;
        logic              logger_running;
    } pssc_in_t;

    typedef struct packed {
        logic        status_changed;
        logic        pump_drive_out;
        logic [1:0]  pump_status;
        logic        delays_valid;
        logic [30:0] drain_delay_ms;
        logic [30:0] rise_delay_ms;
    } pssc_out_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_DIVIDE,
        S_DECIDE,
        S_OUTPUT
    } pssc_state_t;

    typedef struct packed {
        logic load;
        logic div_step;
        logic decide;
    } pssc_cmd_t;

    typedef struct packed {
        logic div_done;
    } pssc_stat_t;

endpackage

### design/pssc_ctrl.sv
// ----------------------------------------------------------------------------
// pssc_ctrl
// Sequencer: load item, run the offset division, decide, present the result.
// ----------------------------------------------------------------------------
module pssc_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    output logic                 out_valid,
    input  logic                 out_stall,
    output pssc_pkg::pssc_cmd_t  cmd,
    input  pssc_pkg::pssc_stat_t stat
);
    import pssc_pkg::*;

    pssc_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        in_stall     = 1'b1;
        out_valid    = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DIVIDE;
                end
            end
            S_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_done)
                    state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = S_OUTPUT;
            end
            S_OUTPUT:
            begin
                out_valid = 1'b1;
                if (!out_stall)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DECIDE) |=> (state_reg == S_OUTPUT))
        else $error("decide not followed by output");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
        else $error("result dropped under stall");
    assert property (@(posedge clk) disable iff (!rst_n)
        !(out_valid && !in_stall))
        else $error("input taken while result pending");

endmodule

### design/pssc_datapath.sv
// ----------------------------------------------------------------------------
// pssc_datapath
// Configuration, state, restoring divider for the cycle offset, decision.
// ----------------------------------------------------------------------------
module pssc_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [pssc_pkg::REG_ADDR_W-1:0]     cfg_index,
    input  logic [pssc_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  pssc_pkg::pssc_in_t                  in_item,
    output pssc_pkg::pssc_out_t                 out_item,
    input  pssc_pkg::pssc_cmd_t                 cmd,
    output pssc_pkg::pssc_stat_t                stat
);
    import pssc_pkg::*;

    logic [16:0] win_start_reg, win_stop_reg, on_time_reg, off_time_reg;
    logic [15:0] rise_limit_reg, poll_period_reg;

    logic [1:0]  status_reg;
    logic        drive_reg, checked_reg, changed_reg;
    logic [31:0] pump_t0_reg, poll_t0_reg, rise_reg, drain_reg;

    pssc_in_t    item_reg;
    logic [47:0] limit_reg;          // rise limit in ms
    logic [DIV_W-1:0] rem_reg;
    logic [16:0] quo_src_reg;        // dividend bits still to shift in
    logic [4:0]  cnt_reg;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_start_reg   <= '0;
            win_stop_reg    <= '0;
            on_time_reg     <= '0;
            off_time_reg    <= '0;
            rise_limit_reg  <= 16'd60;
            poll_period_reg <= 16'd1000;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_WINDOW_START: win_start_reg   <= cfg_data;
                REG_WINDOW_STOP:  win_stop_reg    <= cfg_data;
                REG_ON_TIME:      on_time_reg     <= cfg_data;
                REG_OFF_TIME:     off_time_reg    <= cfg_data;
                REG_RISE_LIMIT:   rise_limit_reg  <= cfg_data[15:0];
                REG_POLL_PERIOD:  poll_period_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // divider: offset = (day - start) mod (on + off), one bit per step
    logic [DIV_W-1:0] cycle;
    logic [DIV_W-1:0] trial;
    logic [16:0]      diff;
    assign cycle = {1'b0, on_time_reg} + {1'b0, off_time_reg};
    assign diff  = in_item.day_second - win_start_reg;
    assign trial = {rem_reg[DIV_W-2:0], quo_src_reg[16]};
    assign stat.div_done = (cnt_reg == 5'd16);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg    <= in_item;
            rem_reg     <= '0;
            quo_src_reg <= diff;
            limit_reg   <= 48'(rise_limit_reg) * 48'(MS_PER_SECOND);
        end
        else if (cmd.div_step)
        begin
            rem_reg     <= (trial >= cycle) ? trial - cycle : trial;
            quo_src_reg <= {quo_src_reg[15:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (cmd.load)
            cnt_reg <= '0;
        else if (cmd.div_step && !stat.div_done)
            cnt_reg <= cnt_reg + 5'd1;
    end

    // decision
    logic        level_ok, due, in_win, sched, pump, upd;
    logic [31:0] now, el_pump, el_poll;
    logic [1:0]  sw, st;
    logic [31:0] rise_meas, drain_meas;
    logic [31:0] rise_next, drain_next;
    logic        checked_next, veto;

    always_comb
    begin
        now      = item_reg.now_ms;
        sw       = item_reg.switch_reading;
        level_ok = (item_reg.level_reading > 16'sd0);
        el_pump  = now - pump_t0_reg;
        el_poll  = now - poll_t0_reg;
        rise_meas  = rise_reg;
        drain_meas = drain_reg;
        if (status_reg == ST_STARTED && rise_reg == '0 && sw == SW_ACTIVE)
            rise_meas = el_pump;
        else if (status_reg == ST_DRAINING && drain_reg == '0 && sw == SW_NEUTRAL)
            drain_meas = el_pump;
        rise_next  = rise_meas;
        drain_next = drain_meas;
        due    = (el_poll >= {16'd0, poll_period_reg});
        in_win = (win_start_reg <= item_reg.day_second)
              && (item_reg.day_second < win_stop_reg);
        sched  = in_win && (cycle != '0) && (rem_reg < {1'b0, on_time_reg})
              && item_reg.logger_running;
        checked_next = checked_reg;
        veto   = 1'b0;
        pump   = 1'b0;
        if (item_reg.manual_on)
        begin
            pump         = 1'b1;
            checked_next = 1'b0;
        end
        else if (!sched)
            checked_next = 1'b0;
        else if (!checked_reg)
        begin
            if (!level_ok || sw != SW_NEUTRAL)
                veto = 1'b1;
            else
            begin
                checked_next = 1'b1;
                rise_next    = '0;
                drain_next   = '0;
            end
            pump = !veto;
        end
        else
            pump = !(({16'd0, el_pump} >= limit_reg) && sw != SW_ACTIVE);
        st  = {sw[0], pump};
        upd = due && !sw[1] && (st != status_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg  <= ST_IDLE;
            drive_reg   <= 1'b0;
            checked_reg <= 1'b0;
            changed_reg <= 1'b0;
            pump_t0_reg <= '0;
            poll_t0_reg <= '0;
            rise_reg    <= '0;
            drain_reg   <= '0;
        end
        else if (cmd.decide)
        begin
            changed_reg <= upd;
            if (due)
            begin
                poll_t0_reg <= now;
                checked_reg <= checked_next;
                rise_reg    <= rise_next;
                drain_reg   <= drain_next;
            end
            else
            begin
                rise_reg  <= rise_meas;
                drain_reg <= drain_meas;
            end
            if (upd)
            begin
                status_reg <= st;
                drive_reg  <= pump;
                if (drive_reg != pump)
                    pump_t0_reg <= now;
            end
        end
    end

    logic valid;
    assign valid = (rise_reg != '0) && (drain_reg != '0);
    assign out_item.status_changed = changed_reg;
    assign out_item.pump_drive_out = drive_reg;
    assign out_item.pump_status    = status_reg;
    assign out_item.delays_valid   = valid;
    assign out_item.drain_delay_ms = !valid ? '0
        : (drain_reg[31] ? DELAY_CLAMP : drain_reg[30:0]);
    assign out_item.rise_delay_ms  = !valid ? '0
        : (rise_reg[31] ? DELAY_CLAMP : rise_reg[30:0]);

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.decide |-> ((rem_reg < cycle) || cycle == '0))
        else $error("remainder not reduced");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.decide |-> stat.div_done)
        else $error("decision before division finished");
    assert property (@(posedge clk) disable iff (!rst_n)
        status_reg[0] == drive_reg)
        else $error("status and drive disagree");

endmodule

### design/pump_schedule_safety_controller.sv
// ----------------------------------------------------------------------------
// pump_schedule_safety_controller
// Poll-driven pump scheduler with start interlocks and switch supervision.
// ----------------------------------------------------------------------------
// One item is handled at a time. The item is loaded at the accepting edge,
// then the bit-serial divider reduces the window offset modulo the on plus
// off cycle in 17 steps, and a decision step follows before the result is
// offered. The result waits until taken and the next item can be accepted
// in the cycle after that; no new item is taken while one is in progress.
// Input stall is high from acceptance until the result is taken. Write
// configuration only when idle.
module pump_schedule_safety_controller (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  pssc_pkg::pssc_in_t                in_data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output pssc_pkg::pssc_out_t               out_data,
    input  logic                              cfg_we,
    input  logic [pssc_pkg::REG_ADDR_W-1:0]   cfg_index,
    input  logic [pssc_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import pssc_pkg::*;

    pssc_cmd_t  cmd;
    pssc_stat_t stat;

    // sequencer: keep input stalled through divide and decision, drop stall once the result is taken
    pssc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .stat      (stat)
    );

    // datapath: configuration, controller state, divider and decision
    pssc_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_item   (in_data),
        .out_item  (out_data),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule
